// ----- sv/sbcd_pkg.sv -----
// sbcd_pkg: shared types, constants and the frame length function of the deframer
package sbcd_pkg;

	localparam logic [7:0] SYNC_BYTE  = 8'h9C;
	localparam logic [3:0] COUNT_MASK = 4'h0F;

	localparam logic [1:0] EV_FRAME_BYTE = 2'd0;
	localparam logic [1:0] EV_BAD_SYNC   = 2'd1;
	localparam logic [1:0] EV_TOO_LONG   = 2'd2;

	// command from front to back: one result, or a three result header burst
	typedef struct packed {
		logic        burst;
		logic [1:0]  ev;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic        last;
		logic [3:0]  idx;
		logic [10:0] len;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  out_byte;
		logic        frame_first;
		logic        frame_last;
		logic [3:0]  frame_index;
		logic [10:0] frame_length;
		logic        run_last;
	} res_t;

	function automatic logic [10:0] sbc_frame_len(input logic [7:0] h1, input logic [7:0] bp);
		logic [4:0]  blocks;
		logic [1:0]  mode;
		logic        stereo;
		logic        subs8;
		logic [3:0]  hdr_len;
		logic [11:0] bb;
		logic [12:0] bits;
		logic [9:0]  bytes;
		blocks  = {1'b0, h1[5:4], 2'b00} + 5'd4;
		mode    = h1[3:2];
		stereo  = (mode != 2'd0);
		subs8   = h1[0];
		hdr_len = (subs8 && stereo) ? 4'd12 : ((subs8 || stereo) ? 4'd8 : 4'd6);
		bb      = 12'(blocks) * 12'(bp);
		if (mode < 2'd2) begin
			bits = stereo ? {bb, 1'b0} : {1'b0, bb};
		end else begin
			bits = {1'b0, bb} + ((mode == 2'd3) ? (subs8 ? 13'd8 : 13'd4) : 13'd0);
		end
		bytes = 10'((bits + 13'd7) >> 3);
		return 11'(hdr_len) + 11'(bytes);
	endfunction

endpackage

// ----- sv/sbcd_in_if.sv -----
// sbcd_in_if: input item channel carrying payload bytes
interface sbcd_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        packet_first;
	logic [15:0] packet_len;

	modport source(output valid, output data_byte, output packet_first, output packet_len,
		input ready);
	modport sink(input valid, input data_byte, input packet_first, input packet_len,
		output ready);
endinterface

// ----- sv/sbcd_out_if.sv -----
// sbcd_out_if: result item channel carrying frame bytes and error events
interface sbcd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [7:0]  out_byte;
	logic        frame_first;
	logic        frame_last;
	logic [3:0]  frame_index;
	logic [10:0] frame_length;
	logic        run_last;

	modport source(output valid, output event_res, output out_byte, output frame_first,
		output frame_last, output frame_index, output frame_length, output run_last,
		input ready);
	modport sink(input valid, input event_res, input out_byte, input frame_first,
		input frame_last, input frame_index, input frame_length, input run_last,
		output ready);
endinterface

// ----- sv/sbcd_front.sv -----
// sbcd_front: packet and frame tracking, classifies each item into a command
module sbcd_front import sbcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        packet_first,
	input  logic [15:0] packet_len,
	output logic        push,
	output cmd_t        cmd
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HDR  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	logic        sink_enable_q;
	logic [1:0]  phase_q, phase_d;
	logic [3:0]  frames_left_q, frames_left_d;
	logic [3:0]  done_q, done_d;
	logic [15:0] pkt_left_q, pkt_left_d;
	logic [7:0]  h1_q, h1_d;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [10:0] fbl_q, fbl_d;
	logic [10:0] cur_len_q, cur_len_d;
	logic [10:0] len;
	logic [15:0] plen_m1;

	assign len     = sbc_frame_len(h1_q, data_byte);
	assign plen_m1 = (packet_len != 16'd0) ? packet_len - 16'd1 : 16'd0;

	always_comb begin
		phase_d       = phase_q;
		frames_left_d = frames_left_q;
		done_d        = done_q;
		pkt_left_d    = pkt_left_q;
		h1_d          = h1_q;
		hcnt_d        = hcnt_q;
		fbl_d         = fbl_q;
		cur_len_d     = cur_len_q;
		push          = 1'b0;
		cmd           = '0;
		cmd.idx       = done_q;
		if (accept) begin
			if (packet_first) begin
				pkt_left_d    = plen_m1;
				frames_left_d = data_byte[3:0] & COUNT_MASK;
				done_d        = '0;
				hcnt_d        = '0;
				fbl_d         = '0;
				cur_len_d     = '0;
				phase_d = (sink_enable_q && plen_m1 != 16'd0 && data_byte[3:0] != 4'd0) ?
					PH_HDR : PH_IDLE;
			end else if (phase_q == PH_IDLE || pkt_left_q == 16'd0) begin
				phase_d = PH_IDLE;
			end else begin
				pkt_left_d = pkt_left_q - 16'd1;
				case (phase_q)
					PH_HDR: begin
						case (hcnt_q)
							2'd0: begin
								if (data_byte != SYNC_BYTE) begin
									push    = 1'b1;
									cmd.ev  = EV_BAD_SYNC;
									phase_d = PH_IDLE;
								end else if (pkt_left_q == 16'd1) begin
									push    = 1'b1;
									cmd.ev  = EV_TOO_LONG;
									phase_d = PH_IDLE;
								end else begin
									hcnt_d = 2'd1;
								end
							end
							2'd1: begin
								h1_d = data_byte;
								if (pkt_left_q == 16'd1) begin
									push    = 1'b1;
									cmd.ev  = EV_TOO_LONG;
									phase_d = PH_IDLE;
								end else begin
									hcnt_d = 2'd2;
								end
							end
							default: begin
								push    = 1'b1;
								cmd.len = len;
								if (17'(len) > 17'(pkt_left_q) + 17'd2) begin
									cmd.ev  = EV_TOO_LONG;
									phase_d = PH_IDLE;
								end else begin
									cmd.burst = 1'b1;
									cmd.ev    = EV_FRAME_BYTE;
									cmd.b0    = h1_q;
									cmd.b1    = data_byte;
									cur_len_d = len;
									fbl_d     = len - 11'd3;
									hcnt_d    = '0;
									phase_d   = PH_BODY;
								end
							end
						endcase
					end
					default: begin
						fbl_d    = fbl_q - 11'd1;
						push     = 1'b1;
						cmd.ev   = EV_FRAME_BYTE;
						cmd.b0   = data_byte;
						cmd.len  = cur_len_q;
						cmd.last = (fbl_d == 11'd0);
						if (cmd.last) begin
							done_d        = done_q + 4'd1;
							frames_left_d = frames_left_q - 4'd1;
							hcnt_d        = '0;
							phase_d = (frames_left_d != 4'd0 && pkt_left_d != 16'd0) ?
								PH_HDR : PH_IDLE;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_enable_q <= 1'b0;
			phase_q       <= PH_IDLE;
			frames_left_q <= '0;
			done_q        <= '0;
			pkt_left_q    <= '0;
			h1_q          <= '0;
			hcnt_q        <= '0;
			fbl_q         <= '0;
			cur_len_q     <= '0;
		end else begin
			if (cfg_we) begin
				sink_enable_q <= cfg_wdata;
			end
			phase_q       <= phase_d;
			frames_left_q <= frames_left_d;
			done_q        <= done_d;
			pkt_left_q    <= pkt_left_d;
			h1_q          <= h1_d;
			hcnt_q        <= hcnt_d;
			fbl_q         <= fbl_d;
			cur_len_q     <= cur_len_d;
		end
	end

	// body bytes still owed always fit in what the packet has left
	a_body_fits: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> fbl_q != 11'd0 && {5'd0, fbl_q} <= pkt_left_q)
		else $error("frame body overruns packet");

endmodule

// ----- sv/sbcd_cmd_fifo.sv -----
// sbcd_cmd_fifo: short command queue between front and back
module sbcd_cmd_fifo import sbcd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == CW'(0));
	assign full  = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue underflow");

endmodule

// ----- sv/sbcd_back.sv -----
// sbcd_back: expands queued commands into result items behind an output register
module sbcd_back import sbcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t head,
	input  logic empty,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic       valid_q;
	res_t       res_q;
	res_t       beat;
	logic [1:0] beat_q;
	logic       load;

	assign load      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_comb begin
		beat.event_res    = head.ev;
		beat.out_byte     = head.b0;
		beat.frame_first  = 1'b0;
		beat.frame_last   = head.last;
		beat.frame_index  = head.idx;
		beat.frame_length = head.len;
		beat.run_last     = 1'b1;
		if (head.burst) begin
			beat.frame_last = 1'b0;
			case (beat_q)
				2'd0: begin
					beat.out_byte    = SYNC_BYTE;
					beat.frame_first = 1'b1;
					beat.run_last    = 1'b0;
				end
				2'd1: begin
					beat.out_byte = head.b0;
					beat.run_last = 1'b0;
				end
				default: beat.out_byte = head.b1;
			endcase
		end
	end

	assign pop = load && !empty && (!head.burst || beat_q == 2'd2);

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			res_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				beat_q <= pop ? 2'd0 : beat_q + 2'd1;
			end
		end
	end

	// a burst in progress keeps its command at the queue head
	a_burst_held: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q != 2'd0 |-> !empty && head.burst)
		else $error("burst lost its command");

endmodule

// ----- sv/sbc_media_packet_deframer_unit.sv -----
// sbc_media_packet_deframer_unit: top level of the A2DP SBC media payload deframer
// Takes one payload byte per cycle and splits each packet into SBC frames. Every
// accepted byte yields no result, one result, or, on the third header byte of a frame,
// three results (sync byte and both header bytes). Results leave at one per cycle from
// an output register while out_ch is ready; a queue of QUEUE_DEPTH commands between the
// byte classifier and the result generator soaks up header bursts, so the sustained rate
// is one byte per cycle while out_ch is ready, set by the output port. The input stalls
// only while that queue is full. sink_enable is sampled on a packet's count byte.
module sbc_media_packet_deframer_unit import sbcd_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	sbcd_in_if.sink    in_ch,
	sbcd_out_if.source out_ch
);

	logic accept;
	logic push;
	cmd_t cmd;
	cmd_t head;
	logic empty;
	logic full;
	logic pop;
	res_t res;

	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && !full;

	sbcd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.data_byte    (in_ch.data_byte),
		.packet_first (in_ch.packet_first),
		.packet_len   (in_ch.packet_len),
		.push         (push),
		.cmd          (cmd)
	);

	sbcd_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	sbcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_res   (res)
	);

	assign out_ch.event_res    = res.event_res;
	assign out_ch.out_byte     = res.out_byte;
	assign out_ch.frame_first  = res.frame_first;
	assign out_ch.frame_last   = res.frame_last;
	assign out_ch.frame_index  = res.frame_index;
	assign out_ch.frame_length = res.frame_length;
	assign out_ch.run_last     = res.run_last;

endmodule
